// ----- rtl/core/bdjf_pkg.sv -----
package bdjf_pkg;

  localparam int BYTE_W = 8;
  localparam int MAXF_W = 13;
  localparam int LEN_W  = 12;

  localparam logic [BYTE_W-1:0] OPEN_BRACE  = 8'h7B;
  localparam logic [BYTE_W-1:0] CLOSE_BRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] NUL_BYTE    = 8'h00;

  localparam logic [MAXF_W-1:0] MAX_FRAME_RESET = 13'd1024;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_DONE      = 2'd1,
    EV_TOO_LARGE = 2'd2,
    EV_OVERFLOW  = 2'd3
  } event_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              in_frame;
    event_t            ev;
    logic [LEN_W-1:0]  length;
  } result_t;

endpackage

// ----- rtl/core/bdjf_in_stage.sv -----
module bdjf_in_stage
  import bdjf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              advance,
  output logic              held_valid,
  output logic [BYTE_W-1:0] held_byte
);

  // the stage frees up in the same cycle its byte moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ----- rtl/core/bdjf_scan.sv -----
module bdjf_scan
  import bdjf_pkg::*;
#(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MAXF_W-1:0] cfg_wdata,
  input  logic              advance,
  input  logic [BYTE_W-1:0] held_byte,
  output result_t           res
);

  localparam int CW    = $clog2(BUFFER_BYTES);
  localparam int CMP_W = (CW > MAXF_W) ? CW : MAXF_W;
  localparam logic [CW:0] BUF_LIMIT = (CW+1)'(BUFFER_BYTES);

  logic [MAXF_W-1:0] max_frame;
  logic [CW-1:0]     nest_depth, nest_depth_next;
  logic [CW-1:0]     buffered_count, buffered_count_next;
  logic [CW-1:0]     open_length, open_length_next;
  logic              frame_open, frame_open_next;
  logic              scan_blocked, scan_blocked_next;
  logic [CW:0]       count_inc;
  logic [CW-1:0]     length_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame <= MAX_FRAME_RESET;
    end else if (cfg_we) begin
      max_frame <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nest_depth     <= '0;
      buffered_count <= '0;
      open_length    <= '0;
      frame_open     <= 1'b0;
      scan_blocked   <= 1'b0;
    end else if (advance) begin
      nest_depth     <= nest_depth_next;
      buffered_count <= buffered_count_next;
      open_length    <= open_length_next;
      frame_open     <= frame_open_next;
      scan_blocked   <= scan_blocked_next;
    end
  end

  assign count_inc  = {1'b0, buffered_count} + 1'b1;
  assign length_inc = open_length + 1'b1;

  always_comb begin
    nest_depth_next     = nest_depth;
    buffered_count_next = buffered_count;
    open_length_next    = open_length;
    frame_open_next     = frame_open;
    scan_blocked_next   = scan_blocked;
    res.data            = held_byte;
    res.in_frame        = 1'b0;
    res.ev              = EV_NONE;
    res.length          = '0;

    if (count_inc >= BUF_LIMIT) begin
      // buffer full: drop the byte and start over
      nest_depth_next     = '0;
      buffered_count_next = '0;
      open_length_next    = '0;
      frame_open_next     = 1'b0;
      scan_blocked_next   = 1'b0;
      res.ev              = EV_OVERFLOW;
    end else begin
      buffered_count_next = count_inc[CW-1:0];
      if (!scan_blocked) begin
        if (held_byte == NUL_BYTE) begin
          scan_blocked_next = 1'b1;
          frame_open_next   = 1'b0;
          nest_depth_next   = '0;
          open_length_next  = '0;
        end else if (!frame_open) begin
          if (held_byte == OPEN_BRACE) begin
            frame_open_next  = 1'b1;
            nest_depth_next  = CW'(1);
            open_length_next = CW'(1);
            res.in_frame     = 1'b1;
          end
        end else begin
          open_length_next = length_inc;
          res.in_frame     = 1'b1;
          if (held_byte == OPEN_BRACE) begin
            nest_depth_next = nest_depth + 1'b1;
          end else if (held_byte == CLOSE_BRACE) begin
            nest_depth_next = nest_depth - 1'b1;
            if (nest_depth == CW'(1)) begin
              // outermost brace closed: report and release the buffer
              res.length = LEN_W'(length_inc);
              res.ev = (CMP_W'(length_inc) >= CMP_W'(max_frame)) ? EV_TOO_LARGE : EV_DONE;
              nest_depth_next     = '0;
              buffered_count_next = '0;
              open_length_next    = '0;
              frame_open_next     = 1'b0;
              scan_blocked_next   = 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/bdjf_out_stage.sv -----
module bdjf_out_stage
  import bdjf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              held_valid,
  input  result_t           res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] byte_out,
  output logic              in_frame,
  output logic [1:0]        event_res,
  output logic [LEN_W-1:0]  frame_length
);

  result_t res_q;

  assign advance = held_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign byte_out     = res_q.data;
  assign in_frame     = res_q.in_frame;
  assign event_res    = res_q.ev;
  assign frame_length = res_q.length;

endmodule

// ----- rtl/core/brace_depth_json_framer_unit.sv -----
// brace-depth json framer
//
// in channel: in_valid / in_ready carry one received byte (rx_byte) per request.
// out channel: out_valid / out_ready carry one result per byte: the byte echoed,
// in_frame, event_res (none, frame complete, frame too large, overflow) and
// frame_length, which is nonzero only with a complete or too-large event.
// cfg_we / cfg_wdata write max_frame; no read-back.
//
// an accepted byte is loaded into the input register and then moves through the
// framing logic into the result register.
// throughput is one byte per cycle unless the receiver stalls; the framing
// counters update in a single pass of logic between the two registers.
//
// reset (rst, synchronous) clears both stages and all framing counters and sets
// max_frame to 1024. when the receiver stalls, the result register holds, the
// input register takes one more byte, and in_ready then drops until the
// result is taken.
module brace_depth_json_framer_unit
  import bdjf_pkg::*;
#(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] byte_out,
  output logic              in_frame,
  output logic [1:0]        event_res,
  output logic [LEN_W-1:0]  frame_length,
  input  logic              cfg_we,
  input  logic [MAXF_W-1:0] cfg_wdata
);

  logic              advance;
  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  result_t           res;

  bdjf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  bdjf_scan #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .held_byte (held_byte),
    .res       (res)
  );

  bdjf_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .res          (res),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_out     (byte_out),
    .in_frame     (in_frame),
    .event_res    (event_res),
    .frame_length (frame_length)
  );

endmodule

// ----- rtl/core/bdjf_checker.sv -----
module bdjf_checker
  import bdjf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] byte_out,
  input logic              in_frame,
  input logic [1:0]        event_res,
  input logic [LEN_W-1:0]  frame_length
);

  // a result waiting on the receiver keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(event_res)
      && $stable(frame_length) && $stable(in_frame))
    else $error("stalled result changed");

  // a closing event comes on a byte of the frame
  a_close_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_DONE || event_res == EV_TOO_LARGE) |-> in_frame)
    else $error("frame event outside a frame");

  // an overflow drops the byte from any frame and carries no length
  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_OVERFLOW |-> !in_frame && frame_length == '0)
    else $error("overflow result not clean");

  a_len_only_on_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_NONE |-> frame_length == '0)
    else $error("length without a frame event");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind brace_depth_json_framer_unit bdjf_checker u_bdjf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .byte_out     (byte_out),
  .in_frame     (in_frame),
  .event_res    (event_res),
  .frame_length (frame_length)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import bdjf_pkg::*;

  localparam int BUF_BYTES   = 4096;
  localparam int SETTLE_CYCS = 4;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] byte_out;
  logic              in_frame;
  logic [1:0]        event_res;
  logic [LEN_W-1:0]  frame_length;
  logic              cfg_we = 1'b0;
  logic [MAXF_W-1:0] cfg_wdata = MAX_FRAME_RESET;

  brace_depth_json_framer_unit #(.BUFFER_BYTES(BUF_BYTES)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_out(byte_out), .in_frame(in_frame), .event_res(event_res),
    .frame_length(frame_length),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // framing state as the block should hold it
  logic [MAXF_W-1:0] max_frame_r = MAX_FRAME_RESET;
  logic [LEN_W-1:0]  depth_r = '0;
  logic [LEN_W-1:0]  open_len_r = '0;
  int                held_r = 0;
  bit                open_r = 1'b0;
  bit                blocked_r = 1'b0;

  logic [BYTE_W-1:0] rx_stream[$];
  result_t           result_due[$];
  int                n_queued = 0;
  int                n_accepted = 0;
  int                n_done = 0;
  int                n_big = 0;
  int                n_ovf = 0;
  int                n_settings = 0;
  int                errors = 0;

  function automatic void frame_clear();
    depth_r    = '0;
    open_len_r = '0;
    held_r     = 0;
    open_r     = 1'b0;
    blocked_r  = 1'b0;
  endfunction

  function automatic result_t frame_track(logic [BYTE_W-1:0] b);
    result_t res;
    res.data     = b;
    res.in_frame = 1'b0;
    res.ev       = EV_NONE;
    res.length   = '0;
    if (held_r + 1 >= BUF_BYTES) begin
      frame_clear();
      res.ev = EV_OVERFLOW;
      n_ovf++;
    end else begin
      held_r++;
      if (!blocked_r) begin
        if (b == NUL_BYTE) begin
          // zero byte drops the candidate and stops framing until overflow
          blocked_r  = 1'b1;
          open_r     = 1'b0;
          depth_r    = '0;
          open_len_r = '0;
        end else if (!open_r) begin
          if (b == OPEN_BRACE) begin
            open_r       = 1'b1;
            depth_r      = 1;
            open_len_r   = 1;
            res.in_frame = 1'b1;
          end
        end else begin
          open_len_r++;
          res.in_frame = 1'b1;
          if (b == OPEN_BRACE) begin
            depth_r++;
          end else if (b == CLOSE_BRACE) begin
            depth_r--;
            if (depth_r == 0) begin
              res.length = open_len_r;
              if ({1'b0, open_len_r} >= max_frame_r) begin
                res.ev = EV_TOO_LARGE;
                n_big++;
              end else begin
                res.ev = EV_DONE;
                n_done++;
              end
              frame_clear();
            end
          end
        end
      end
    end
    return res;
  endfunction

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(16, 40);
  endfunction

  // request driver
  int gap_left = 0;
  bit quiet_in = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        result_due.push_back(frame_track(rx_byte));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_stream.size() > 0) begin
          rx_byte  <= rx_stream.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 49) == 0) quiet_in = !quiet_in;
          gap_left = quiet_in ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int      stall_left = 0;
  bit      quiet_out = 1'b0;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_due.size() == 0) begin
          $error("result with no request pending: byte_out %0h", byte_out);
          errors++;
        end else begin
          want = result_due.pop_front();
          if (byte_out !== want.data) begin
            $error("byte_out: expected %0h, got %0h", want.data, byte_out);
            errors++;
          end
          if (in_frame !== want.in_frame) begin
            $error("in_frame: expected %0d, got %0d", want.in_frame, in_frame);
            errors++;
          end
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, event_res);
            errors++;
          end
          if (frame_length !== want.length) begin
            $error("frame_length: expected %0d, got %0d", want.length, frame_length);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) quiet_out = !quiet_out;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void send(logic [BYTE_W-1:0] b);
    rx_stream.push_back(b);
    n_queued++;
  endfunction

  // any byte but a brace or zero
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] v;
    do v = $urandom_range(1, 255);
    while (v == OPEN_BRACE || v == CLOSE_BRACE);
    return v;
  endfunction

  function automatic void queue_noise(int n);
    repeat (n) send(($urandom_range(0, 9) < 3) ? CLOSE_BRACE : plain_byte());
  endfunction

  // one object with random nesting; unclosed leaves off the last brace
  function automatic void queue_object(int body, int nest_cap, bit closed);
    int lvl;
    int r;
    lvl = 1;
    send(OPEN_BRACE);
    repeat (body) begin
      r = $urandom_range(0, 9);
      if (r < 2 && lvl < nest_cap) begin
        send(OPEN_BRACE);
        lvl++;
      end else if (r < 4 && lvl > 1) begin
        send(CLOSE_BRACE);
        lvl--;
      end else begin
        send(plain_byte());
      end
    end
    repeat (closed ? lvl : lvl - 1) send(CLOSE_BRACE);
  endfunction

  function automatic int body_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 10);
    if (r < 95) return $urandom_range(11, 60);
    return $urandom_range(61, 300);
  endfunction

  function automatic void queue_traffic(int n);
    int start;
    int r;
    start = n_queued;
    while (n_queued - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        queue_noise($urandom_range(0, 3));
        queue_object(body_len(), $urandom_range(1, 6), 1'b1);
      end else if (r < 85) begin
        queue_object(body_len(), $urandom_range(1, 6), 1'b1);
      end else if (r < 93) begin
        queue_noise($urandom_range(1, 10));
      end else begin
        queue_object(body_len(), $urandom_range(1, 6), 1'b0);
      end
    end
  endfunction

  task automatic wait_idle();
    while (n_accepted != n_queued || result_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCS) @(posedge clk);
  endtask

  // push the block back to an empty buffer: close, release or overflow
  task automatic settle_empty();
    while (held_r != 0) begin
      if (blocked_r) begin
        repeat (BUF_BYTES - held_r) send(plain_byte());
      end else if (open_r) begin
        repeat (depth_r) send(CLOSE_BRACE);
      end else begin
        send(OPEN_BRACE);
        send(CLOSE_BRACE);
      end
      wait_idle();
    end
  endtask

  task automatic set_max_frame(logic [MAXF_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_frame_r = v;
    n_settings++;
    repeat (SETTLE_CYCS) @(posedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] opening[] = '{8'h41, CLOSE_BRACE, 8'hFF, OPEN_BRACE, 8'h80,
                                     OPEN_BRACE, 8'h01, CLOSE_BRACE, 8'h7F, CLOSE_BRACE,
                                     OPEN_BRACE, CLOSE_BRACE, OPEN_BRACE, 8'h3A, NUL_BYTE,
                                     OPEN_BRACE, CLOSE_BRACE, 8'h55};
    logic [MAXF_W-1:0] plan[$];
    int k;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // prefix, stray close, nested frame, empty frame, zero inside a candidate
    foreach (opening[i]) send(opening[i]);
    wait_idle();
    // blocked until the buffer overflows
    settle_empty();

    // longest frame the buffer can hold, once kept and once discarded
    set_max_frame(13'd4096);
    queue_object(BUF_BYTES - 3, 1, 1'b1);
    wait_idle();
    set_max_frame(13'd4095);
    queue_object(BUF_BYTES - 3, 1, 1'b1);
    wait_idle();

    // nesting until overflow
    repeat (BUF_BYTES) send(OPEN_BRACE);
    wait_idle();
    settle_empty();

    plan = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd8191};
    plan.push_back($urandom_range(4, 64));
    plan.push_back($urandom_range(4, 64));
    plan.push_back($urandom_range(65, 400));
    plan.push_back($urandom_range(1, 4096));
    plan.push_back(13'd4096);
    plan.push_back($urandom_range(4, 32));
    plan.push_back(MAX_FRAME_RESET);

    for (k = 0; k < plan.size(); k++) begin
      set_max_frame(plan[k]);
      queue_traffic(146);
      if (k == 3 || k == 8) begin
        // zero byte mid-stream, then bytes that only fill the buffer
        send(NUL_BYTE);
        queue_traffic(20);
      end
      wait_idle();
      settle_empty();
    end

    $display("%0d bytes over %0d max_frame settings", n_queued, n_settings);
    $display("%0d frames complete, %0d discarded as too large, %0d overflow resets",
             n_done, n_big, n_ovf);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout: %0d of %0d requests accepted", n_accepted, n_queued);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
